>>> sv/crkc_pkg.sv
`default_nettype none

package crkc_pkg;

   localparam int CAPACITY_DEF    = 8;
   localparam int HANDLE_BITS_DEF = 16;
   localparam int HASH_WORDS      = 4;

   // result status codes
   localparam logic [2:0] STATUS_HIT    = 3'd0;
   localparam logic [2:0] STATUS_FILL   = 3'd1;
   localparam logic [2:0] STATUS_EVICT  = 3'd2;
   localparam logic [2:0] STATUS_MISS   = 3'd3;
   localparam logic [2:0] STATUS_BYPASS = 3'd4;

   typedef struct packed {
      logic [31:0] key_epoch;
      logic [63:0] block_hash_w0;
      logic [63:0] block_hash_w1;
      logic [63:0] block_hash_w2;
      logic [63:0] block_hash_w3;
      logic [63:0] bundle_hash_w0;
      logic [63:0] bundle_hash_w1;
      logic [63:0] bundle_hash_w2;
      logic [63:0] bundle_hash_w3;
      logic [15:0] new_handle;
      logic        publish;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slot;
      logic [15:0] handle_out;
      logic [15:0] evicted_handle;
   } rsp_type;

   typedef struct packed {
      logic [31:0]                 epoch;
      logic [HASH_WORDS-1:0][63:0] block_hash;
      logic [HASH_WORDS-1:0][63:0] bundle_hash;
   } key_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic compare;
      logic hit_start;
      logic fill;
      logic sweep;
      logic hit_done;
      logic evict_done;
      logic set_bypass;
      logic set_miss;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic enable;
      logic publish;
      logic any_hit;
      logic any_empty;
      logic hand_used;
   } ctrl_status_type;

endpackage

`default_nettype wire

>>> sv/crkc_datapath.sv
`default_nettype none

module crkc_datapath
   import crkc_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_type         req_data,
   input  wire logic            csr_write,
   input  wire logic            csr_data,
   input  wire ctrl_cmd_type    cmd,
   output ctrl_status_type      status,
   output rsp_type              rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   req_type                 req_ff;
   logic                    enable_ff, enable_in;
   logic [CAPACITY-1:0]     valid_ff, valid_in;
   logic [CAPACITY-1:0]     used_ff, used_in;
   logic [CAPACITY-1:0]     match_ff, match_in;
   logic [IDX_W-1:0]        hand_ff, hand_in;
   logic [IDX_W-1:0]        victim_ff, victim_in;
   rsp_type                 rsp_ff, rsp_in;
   key_type                 key_ff [CAPACITY];
   logic [HANDLE_BITS-1:0]  handle_mem [CAPACITY];
   logic [HANDLE_BITS-1:0]  rd_data_ff;

   key_type                 req_key;
   logic [IDX_W-1:0]        hit_idx, empty_idx, wr_idx, rd_idx, hand_next;
   logic                    any_hit, any_empty, wr_en;
   logic [HANDLE_BITS-1:0]  handle_q;
   logic [15:0]             new_out;

   always_comb begin
      req_key.epoch          = req_ff.key_epoch;
      req_key.block_hash[0]  = req_ff.block_hash_w0;
      req_key.block_hash[1]  = req_ff.block_hash_w1;
      req_key.block_hash[2]  = req_ff.block_hash_w2;
      req_key.block_hash[3]  = req_ff.block_hash_w3;
      req_key.bundle_hash[0] = req_ff.bundle_hash_w0;
      req_key.bundle_hash[1] = req_ff.bundle_hash_w1;
      req_key.bundle_hash[2] = req_ff.bundle_hash_w2;
      req_key.bundle_hash[3] = req_ff.bundle_hash_w3;
   end

   assign handle_q = HANDLE_BITS'(req_ff.new_handle);
   assign new_out  = 16'(handle_q);

   // lowest matching entry and lowest empty entry
   always_comb begin
      hit_idx   = '0;
      empty_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_idx = IDX_W'(i);
         if (!valid_ff[i]) empty_idx = IDX_W'(i);
      end
   end

   assign any_hit   = |match_ff;
   assign any_empty = ~&valid_ff;
   assign hand_next = (hand_ff == IDX_W'(CAPACITY - 1)) ? '0 : hand_ff + IDX_W'(1);
   assign wr_en     = cmd.fill | cmd.evict_done;
   assign wr_idx    = cmd.fill ? empty_idx : victim_ff;
   assign rd_idx    = cmd.hit_start ? hit_idx : hand_ff;

   always_comb begin
      enable_in = csr_write ? csr_data : enable_ff;
      valid_in  = valid_ff;
      used_in   = used_ff;
      match_in  = match_ff;
      hand_in   = hand_ff;
      victim_in = victim_ff;
      rsp_in    = rsp_ff;

      if (cmd.compare) begin
         for (int i = 0; i < CAPACITY; i++) begin
            match_in[i] = valid_ff[i] && (key_ff[i] == req_key);
         end
      end

      if (cmd.hit_start) begin
         used_in[hit_idx] = 1'b1;
         victim_in        = hit_idx;
      end

      if (cmd.fill) begin
         valid_in[empty_idx]   = 1'b1;
         used_in[empty_idx]    = 1'b1;
         rsp_in.status         = STATUS_FILL;
         rsp_in.slot           = 3'(empty_idx);
         rsp_in.handle_out     = new_out;
         rsp_in.evicted_handle = '0;
      end

      // second chance: clear a set used bit, stop on a clear one
      if (cmd.sweep) begin
         if (used_ff[hand_ff]) begin
            used_in[hand_ff] = 1'b0;
         end else begin
            victim_in = hand_ff;
         end
         hand_in = hand_next;
      end

      if (cmd.hit_done) begin
         rsp_in.status         = STATUS_HIT;
         rsp_in.slot           = 3'(victim_ff);
         rsp_in.handle_out     = 16'(rd_data_ff);
         rsp_in.evicted_handle = '0;
      end

      if (cmd.evict_done) begin
         used_in[victim_ff]    = 1'b1;
         rsp_in.status         = STATUS_EVICT;
         rsp_in.slot           = 3'(victim_ff);
         rsp_in.handle_out     = new_out;
         rsp_in.evicted_handle = 16'(rd_data_ff);
      end

      if (cmd.set_bypass || cmd.set_miss) begin
         rsp_in.status         = cmd.set_bypass ? STATUS_BYPASS : STATUS_MISS;
         rsp_in.slot           = '0;
         rsp_in.handle_out     = new_out;
         rsp_in.evicted_handle = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         valid_ff  <= '0;
         used_ff   <= '0;
         hand_ff   <= '0;
      end else begin
         enable_ff <= enable_in;
         valid_ff  <= valid_in;
         used_ff   <= used_in;
         hand_ff   <= hand_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff  <= match_in;
      victim_ff <= victim_in;
      rsp_ff    <= rsp_in;
      if (cmd.load) req_ff <= req_data;
   end

   // key lanes, each compared at its own place
   always_ff @(posedge clock) begin
      if (wr_en) key_ff[wr_idx] <= req_key;
   end

   // handle memory
   always_ff @(posedge clock) begin
      if (wr_en) handle_mem[wr_idx] <= handle_q;
      rd_data_ff <= handle_mem[rd_idx];
   end

   assign status.enable    = enable_ff;
   assign status.publish   = req_ff.publish;
   assign status.any_hit   = any_hit;
   assign status.any_empty = any_empty;
   assign status.hand_used = used_ff[hand_ff];
   assign rsp_data         = rsp_ff;

   a_hit_has_match: assert property (@(posedge clock) disable iff (reset)
      cmd.hit_start |-> any_hit)
      else $error("hit issued without a matching entry");

   a_fill_marks_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |=> valid_ff[$past(empty_idx)] && used_ff[$past(empty_idx)])
      else $error("filled entry not marked valid and used");

   a_evict_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.evict_done |-> valid_ff[victim_ff] && !any_empty)
      else $error("eviction of an entry that is not valid");

endmodule

`default_nettype wire

>>> sv/crkc_ctrl.sv
`default_nettype none

module crkc_ctrl
   import crkc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire ctrl_status_type  status,
   output ctrl_cmd_type          cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_CHECK    = 7'b0000010,
      S_DECIDE   = 7'b0000100,
      S_SWEEP    = 7'b0001000,
      S_HIT_RD   = 7'b0010000,
      S_EVICT_RD = 7'b0100000,
      S_RESP     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!status.enable) begin
               cmd.set_bypass = 1'b1;
               state_in       = S_RESP;
            end else begin
               cmd.compare = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.any_hit) begin
               cmd.hit_start = 1'b1;
               state_in      = S_HIT_RD;
            end else if (!status.publish) begin
               cmd.set_miss = 1'b1;
               state_in     = S_RESP;
            end else if (status.any_empty) begin
               cmd.fill = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (!status.hand_used) state_in = S_EVICT_RD;
         end
         S_HIT_RD: begin
            cmd.hit_done = 1'b1;
            state_in     = S_RESP;
         end
         S_EVICT_RD: begin
            cmd.evict_done = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result beat dropped");

endmodule

`default_nettype wire

>>> sv/clock_replacement_keyed_cache.sv
`default_nettype none

// channel   ports                                   beat
// req       req_valid  req_stall  req_data         one lookup / publish request
// rsp       rsp_valid  rsp_stall  rsp_data         one result per request
// csr       csr_valid  csr_ready  csr_data         cache_enable write, always ready
//
// one request at a time; bypass runs S_CHECK, S_RESP; miss or fill S_CHECK,
// S_DECIDE, S_RESP; a hit adds S_HIT_RD and an eviction S_SWEEP (clock hand sweep
// of 1 to CAPACITY + 1 entries, one entry per cycle) and S_EVICT_RD before S_RESP;
// back to idle after the result beat. keys are compared in parallel; the handle
// memory read is registered. reset is synchronous: cache empty, hand at 0, cache
// enabled. a stalled result holds and no request is taken until it leaves.

module clock_replacement_keyed_cache
   import crkc_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   crkc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   crkc_datapath #(
      .CAPACITY    (CAPACITY),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
